@@ hw/rtl/fitness_sharing_niche_count_macros.svh @@
// Assertion macros shared by the niche count block.
`ifndef FITNESS_SHARING_NICHE_COUNT_MACROS_SVH
`define FITNESS_SHARING_NICHE_COUNT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FSNC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FSNC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/fsnc_pkg.sv @@
// Package with widths, constants and controller/datapath types for the niche count block.
package fsnc_pkg;

    // Field and datapath widths.
    localparam int COORD_W  = 24;
    localparam int MAG_W    = 24;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 60;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 2;
    localparam int SIGMA_W  = 23;
    localparam int FRAC_W   = 16;
    localparam int QUO_W    = FRAC_W + 1;
    localparam int NICHE_W  = 27;

    // Iteration counts of the shared square root and divider steps.
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = QUO_W;
    localparam int CNT_W      = 5;

    // Configuration port.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_SIGMA = '0;
    localparam logic [SIGMA_W-1:0]   SIGMA_RESET = 23'd65536;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic mul;
        logic acc;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic niche_add;
        logic emit;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last_coord;
        logic last_member;
        logic in_radius;
        logic out_full;
    } t_dp_status;

endpackage

@@ hw/rtl/fsnc_if.sv @@
// Valid/ready channel interfaces for coordinate pairs and niche count results.
interface fsnc_in_if;
    import fsnc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] own_coord;
    logic signed [COORD_W-1:0] other_coord;
    logic                      last_coord;
    logic                      last_member;

    modport source (output valid, output own_coord, output other_coord,
                    output last_coord, output last_member, input ready);
    modport sink (input valid, input own_coord, input other_coord,
                  input last_coord, input last_member, output ready);
endinterface

interface fsnc_out_if;
    import fsnc_pkg::*;

    logic               valid;
    logic               ready;
    logic [NICHE_W-1:0] share_sum;
    logic               distance_saturated;

    modport source (output valid, output share_sum, output distance_saturated,
                    input ready);
    modport sink (input valid, input share_sum, input distance_saturated,
                  output ready);
endinterface

@@ hw/rtl/fsnc_datapath.sv @@
// Datapath: squared distance accumulation, bit-serial square root and division, niche sum.
module fsnc_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [fsnc_pkg::SIGMA_W-1:0]       i_sigma,
    input  logic signed [fsnc_pkg::COORD_W-1:0] i_own_coord,
    input  logic signed [fsnc_pkg::COORD_W-1:0] i_other_coord,
    input  logic                               i_last_coord,
    input  logic                               i_last_member,
    input  fsnc_pkg::t_dp_cmd                  i_cmd,
    output fsnc_pkg::t_dp_status               o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic [fsnc_pkg::NICHE_W-1:0]       o_share_sum,
    output logic                               o_distance_saturated
);
    import fsnc_pkg::*;

    logic [MAG_W-1:0]   r_mag;
    logic               r_lc;
    logic               r_lm;
    logic [SQ_W-1:0]    r_sq;
    logic [SUM_W-1:0]   r_sum;
    logic               r_sat;
    logic [REM_W-1:0]   r_rem;
    logic [ROOT_W-1:0]  r_root;
    logic [SIGMA_W-1:0] r_dr;
    logic [QUO_W-1:0]   r_num;
    logic [QUO_W-1:0]   r_quo;
    logic [NICHE_W-1:0] r_niche;
    logic               r_out_valid;
    logic [NICHE_W-1:0] r_out_niche;
    logic               r_out_sat;

    logic [COORD_W:0]   w_diff;
    logic [COORD_W:0]   w_neg;
    logic [MAG_W-1:0]   w_mag;
    logic [SUM_W:0]     w_total;
    logic [REM_W+1:0]   w_cur;
    logic [REM_W+1:0]   w_trial;
    logic [REM_W+1:0]   w_rsub;
    logic               w_rge;
    logic [SIGMA_W:0]   w_dtrial;
    logic [SIGMA_W:0]   w_dsub;
    logic               w_dge;
    logic [SIGMA_W-1:0] w_span;
    logic [NICHE_W:0]   w_nsum;

    // Absolute difference of the coordinate pair, exact in 25 bits.
    assign w_diff = {i_own_coord[COORD_W-1], i_own_coord}
                  - {i_other_coord[COORD_W-1], i_other_coord};
    assign w_neg  = (COORD_W+1)'(0) - w_diff;
    assign w_mag  = w_diff[COORD_W] ? w_neg[MAG_W-1:0] : w_diff[MAG_W-1:0];

    // Saturating accumulation of the squared difference.
    assign w_total = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    // One square root digit: bring down two bits of the sum and try the subtraction.
    assign w_cur   = {r_rem, r_sum[SUM_W-1 -: 2]};
    assign w_trial = {2'b00, r_root, 2'b01};
    assign w_rge   = (w_cur >= w_trial);
    assign w_rsub  = w_cur - w_trial;

    // One restoring division step of (sigma - d) * 2^16 by sigma.
    assign w_span   = i_sigma - r_root[SIGMA_W-1:0];
    assign w_dtrial = {r_dr, r_num[QUO_W-1]};
    assign w_dge    = (w_dtrial >= {1'b0, i_sigma});
    assign w_dsub   = w_dtrial - {1'b0, i_sigma};

    // Saturating niche sum update.
    assign w_nsum = {1'b0, r_niche} + (NICHE_W+1)'(r_quo);

    // Payload registers of the current item and the iterative units.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mag <= w_mag;
            r_lc  <= i_last_coord;
            r_lm  <= i_last_member;
        end
        if (i_cmd.mul) begin
            r_sq <= r_mag * r_mag;
        end
        if (i_cmd.acc) begin
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rem  <= w_rge ? w_rsub[REM_W-1:0] : w_cur[REM_W-1:0];
            r_root <= {r_root[ROOT_W-2:0], w_rge};
        end
        if (i_cmd.div_init) begin
            r_dr  <= {1'b0, w_span[SIGMA_W-1:1]};
            r_num <= {w_span[0], {(QUO_W-1){1'b0}}};
            r_quo <= '0;
        end else if (i_cmd.div_step) begin
            r_dr  <= w_dge ? w_dsub[SIGMA_W-1:0] : w_dtrial[SIGMA_W-1:0];
            r_num <= {r_num[QUO_W-2:0], 1'b0};
            r_quo <= {r_quo[QUO_W-2:0], w_dge};
        end
        if (i_cmd.emit) begin
            r_out_niche <= r_niche;
            r_out_sat   <= r_sat;
        end
    end

    // Running sums and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_sat       <= 1'b0;
            r_niche     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // The square root shifts the sum out, which leaves it cleared for the next member.
            if (i_cmd.acc) begin
                if (w_total[SUM_W]) begin
                    r_sum <= '1;
                    r_sat <= 1'b1;
                end else begin
                    r_sum <= w_total[SUM_W-1:0];
                end
            end else if (i_cmd.sqrt_step) begin
                r_sum <= {r_sum[SUM_W-3:0], 2'b00};
            end
            if (i_cmd.niche_add) begin
                r_niche <= w_nsum[NICHE_W] ? '1 : w_nsum[NICHE_W-1:0];
            end
            if (i_cmd.emit) begin
                r_niche     <= '0;
                r_sat       <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.last_coord  = r_lc;
    assign o_status.last_member = r_lm;
    assign o_status.in_radius   = (r_root < {(ROOT_W-SIGMA_W)'(0), i_sigma});
    assign o_status.out_full    = r_out_valid;

    assign o_out_valid          = r_out_valid;
    assign o_share_sum          = r_out_niche;
    assign o_distance_saturated = r_out_sat;

endmodule

@@ hw/rtl/fsnc_ctrl.sv @@
// Controller state machine sequencing one coordinate pair through the datapath.
module fsnc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fsnc_pkg::t_dp_status i_status,
    output fsnc_pkg::t_dp_cmd    o_cmd
);
    import fsnc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_SQRT = 3'd3;
    localparam logic [2:0] S_CMP  = 3'd4;
    localparam logic [2:0] S_DIV  = 3'd5;
    localparam logic [2:0] S_ADD  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]       r_state;
    logic [2:0]       n_state;
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;

    // Next state, step counter and datapath commands.
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_cnt     = '0;
                n_state   = i_status.last_coord ? S_SQRT : S_IDLE;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CMP: begin
                // Outside the radius the quotient stays cleared and the share is zero.
                o_cmd.div_init = 1'b1;
                n_state        = i_status.in_radius ? S_DIV : S_ADD;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ADD: begin
                o_cmd.niche_add = 1'b1;
                n_state         = i_status.last_member ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!i_status.out_full) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

@@ hw/rtl/fitness_sharing_niche_count.sv @@
// Top level of the triangular fitness-sharing niche count block.
// An ordinary coordinate pair passes through the multiply and accumulate states before the next input transfer.
// A member's last coordinate adds 30 square root steps, one compare, 17 divide steps and
// one add; the divide is skipped when the distance reaches sigma.
// After the last member the controller waits until the output register is free, then loads the result.
// Synchronous active-low reset clears all sums and the output valid flag, and sets sigma to 1.0.
`include "fitness_sharing_niche_count_macros.svh"

module fitness_sharing_niche_count (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    fsnc_in_if.sink                         i_in,
    fsnc_out_if.source                      o_out,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [fsnc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [fsnc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [fsnc_pkg::APB_DATA_W-1:0] prdata,
    output logic                            pready
);
    import fsnc_pkg::*;

    logic [SIGMA_W-1:0] r_sigma;
    logic               w_sel_sigma;
    t_dp_cmd            w_cmd;
    t_dp_status         w_status;

    // Configuration register, written in the access phase of an APB transfer.
    assign w_sel_sigma = (paddr[APB_ADDR_W-1:2] == REG_SIGMA);
    assign pready      = 1'b1;
    assign prdata      = w_sel_sigma ? APB_DATA_W'(r_sigma) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sigma <= SIGMA_RESET;
        end else if (psel && penable && pwrite && pready && w_sel_sigma) begin
            r_sigma <= pwdata[SIGMA_W-1:0];
        end
    end

    // Sequencer.
    fsnc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // Arithmetic and output register.
    fsnc_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_sigma              (r_sigma),
        .i_own_coord          (i_in.own_coord),
        .i_other_coord        (i_in.other_coord),
        .i_last_coord         (i_in.last_coord),
        .i_last_member        (i_in.last_member),
        .i_cmd                (w_cmd),
        .o_status             (w_status),
        .i_out_ready          (o_out.ready),
        .o_out_valid          (o_out.valid),
        .o_share_sum          (o_out.share_sum),
        .o_distance_saturated (o_out.distance_saturated)
    );

    // A transfer in starts work, so the controller stops taking items for a while.
    `FSNC_ASSERT_NEXT(a_busy_after_input, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready, "input accepted while still busy")
    // The output register cannot be refilled in the cycle it is emptied.
    `FSNC_ASSERT_NEXT(a_out_gap, i_clk, i_rst_n, o_out.valid && o_out.ready, !o_out.valid, "result reloaded on its own transfer")
    // A result only appears at the end of the last member's processing.
    `FSNC_ASSERT_NOW(a_result_from_work, i_clk, i_rst_n, $rose(o_out.valid), !$past(i_in.ready), "result appeared while idle")

endmodule

@@ sim/tb_fitness_sharing_niche_count.sv @@
// Self-checking testbench for the niche count block: streams coordinate pairs, checks results.
module tb_fitness_sharing_niche_count;
    timeunit 1ns;
    timeprecision 1ps;

    import fsnc_pkg::*;

    localparam int CLK_HALF = 4;
    localparam int IDLE_MAX = 11;
    localparam int DRAIN_CYCLES = 100;
    localparam int DIMS_LIMIT = 20;
    localparam longint TIMEOUT_NS = 64'd10_000_000;

    // Register index with nothing behind it; writes there must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = 1'b1;

    localparam logic [63:0] SUMSQ_LIMIT = (64'd1 << SUM_W) - 64'd1;
    localparam logic [63:0] NICHE_LIMIT = (64'd1 << NICHE_W) - 64'd1;
    localparam logic [63:0] SHARE_ONE = 64'd1 << FRAC_W;
    localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [SIGMA_W-1:0] SIGMA_MAX = '1;

    typedef struct packed {
        logic [COORD_W-1:0] own_coord;
        logic [COORD_W-1:0] other_coord;
        logic               last_coord;
        logic               last_member;
    } t_coord_pair;

    typedef struct packed {
        logic [NICHE_W-1:0] share_sum;
        logic               distance_saturated;
    } t_niche_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    fsnc_in_if  in_if();
    fsnc_out_if out_if();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    fitness_sharing_niche_count DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Pairs waiting to be sent and niche counts waiting to come out.
    t_coord_pair   pair_queue[$];
    t_niche_result niche_expect[$];
    int            error_count = 0;

    // Predictor state, mirroring the block's accumulators and the niche radius.
    logic [63:0]        sq_accum = '0;
    logic [63:0]        niche_accum = '0;
    logic               sat_flag = 1'b0;
    logic [SIGMA_W-1:0] radius = SIGMA_RESET;

    // Handshake bookkeeping between the clocked blocks.
    logic pair_busy = 1'b0;
    logic pair_taken = 1'b0;
    int   send_gap = 0;
    logic send_burst = 1'b0;
    logic result_stall_set = 1'b0;
    int   result_stall = 0;
    logic result_burst = 1'b0;

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Floor of the square root, one result bit at a time from the top.
    function automatic logic [63:0] root_floor(input logic [63:0] x);
        logic [63:0] root;
        logic [63:0] trial;
        root = '0;
        for (int b = ROOT_W - 1; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x) begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Triangular share in Q1.16: zero at or beyond the radius.
    function automatic logic [63:0] share_of(input logic [63:0] spacing,
                                             input logic [SIGMA_W-1:0] r);
        logic [63:0] r64;
        r64 = 64'(r);
        if (spacing >= r64) begin
            return '0;
        end
        return ((r64 - spacing) * SHARE_ONE) / r64;
    endfunction

    // Advance the niche count prediction by one accepted pair.
    task automatic predict_niche(input t_coord_pair p);
        logic signed [COORD_W:0] diff;
        logic [COORD_W:0]        abs_diff;
        logic [63:0]             total;
        t_niche_result           res;
        diff = $signed({p.own_coord[COORD_W-1], p.own_coord})
             - $signed({p.other_coord[COORD_W-1], p.other_coord});
        abs_diff = diff[COORD_W] ? -diff : diff;
        total = sq_accum + 64'(abs_diff) * 64'(abs_diff);
        if (total > SUMSQ_LIMIT) begin
            total = SUMSQ_LIMIT;
            sat_flag = 1'b1;
        end
        sq_accum = total;
        if (p.last_coord) begin
            niche_accum = niche_accum + share_of(root_floor(sq_accum), radius);
            if (niche_accum > NICHE_LIMIT) begin
                niche_accum = NICHE_LIMIT;
            end
            sq_accum = '0;
            if (p.last_member) begin
                res.share_sum = niche_accum[NICHE_W-1:0];
                res.distance_saturated = sat_flag;
                niche_expect.push_back(res);
                niche_accum = '0;
                sat_flag = 1'b0;
            end
        end
    endtask

    // Input side: every transfer updates the prediction.
    always @(posedge i_clk) begin : pair_monitor
        t_coord_pair seen;
        if (i_rst_n && in_if.valid && in_if.ready) begin
            seen.own_coord = in_if.own_coord;
            seen.other_coord = in_if.other_coord;
            seen.last_coord = in_if.last_coord;
            seen.last_member = in_if.last_member;
            predict_niche(seen);
            pair_taken = 1'b1;
        end
    end

    // Pair driver: holds each pair until its transfer, then idles a random gap.
    always @(negedge i_clk) begin : pair_driver
        t_coord_pair next_pair;
        if (!i_rst_n) begin
            in_if.valid <= 1'b0;
        end else if (!pair_busy || pair_taken) begin
            if (pair_taken) begin
                pair_taken = 1'b0;
                pair_busy = 1'b0;
                if ($urandom_range(0, 15) == 0) begin
                    send_burst = !send_burst;
                end
                send_gap = send_burst ? 0 : $urandom_range(0, IDLE_MAX);
            end
            if (send_gap > 0) begin
                send_gap--;
                in_if.valid <= 1'b0;
            end else if (pair_queue.size() > 0) begin
                next_pair = pair_queue.pop_front();
                in_if.own_coord <= next_pair.own_coord;
                in_if.other_coord <= next_pair.other_coord;
                in_if.last_coord <= next_pair.last_coord;
                in_if.last_member <= next_pair.last_member;
                in_if.valid <= 1'b1;
                pair_busy = 1'b1;
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    // Result side ready: a random stall per result and random toggling while idle, both off during a burst.
    always @(negedge i_clk) begin : result_ready
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else if (out_if.valid) begin
            if (!result_stall_set) begin
                if ($urandom_range(0, 7) == 0) begin
                    result_burst = !result_burst;
                end
                result_stall = result_burst ? 0 : $urandom_range(0, IDLE_MAX);
                result_stall_set = 1'b1;
            end
            if (result_stall > 0) begin
                result_stall--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end else begin
            out_if.ready <= result_burst ? 1'b1 : ($urandom_range(0, 1) == 1);
        end
    end

    // Result checker: each transfer is compared with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_niche_result want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            result_stall_set = 1'b0;
            if (niche_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual share_sum=%0d sat=%0b",
                         $time, out_if.share_sum, out_if.distance_saturated);
                error_count++;
            end else begin
                want = niche_expect.pop_front();
                if (out_if.share_sum !== want.share_sum) begin
                    $display("%0t: share_sum mismatch, expected %0d, actual %0d",
                             $time, want.share_sum, out_if.share_sum);
                    error_count++;
                end
                if (out_if.distance_saturated !== want.distance_saturated) begin
                    $display("%0t: distance_saturated mismatch, expected %0b, actual %0b",
                             $time, want.distance_saturated, out_if.distance_saturated);
                    error_count++;
                end
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (idx == REG_SIGMA) begin
            radius = value[SIGMA_W-1:0];
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Register read, checked against an expected value.
    task automatic cfg_read_check(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] want);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== want) begin
            $display("%0t: register read mismatch, expected %0d, actual %0d",
                     $time, want, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Let the stream drain and the block finish any member still in flight.
    task automatic wait_idle();
        while (pair_queue.size() != 0 || pair_busy || niche_expect.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_pair(input logic [COORD_W-1:0] own, input logic [COORD_W-1:0] other,
                              input logic lc, input logic lm);
        t_coord_pair p;
        p.own_coord = own;
        p.other_coord = other;
        p.last_coord = lc;
        p.last_member = lm;
        pair_queue.push_back(p);
    endtask

    // Coordinates lean toward the extremes and zero.
    function automatic logic [COORD_W-1:0] pick_coord();
        unique case ($urandom_range(0, 7))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            default: return COORD_W'($urandom());
        endcase
    endfunction

    // Partner coordinate mostly within a span of the individual's, so shares are nonzero.
    function automatic logic [COORD_W-1:0] pick_partner(input logic [COORD_W-1:0] own,
                                                        input int span);
        int delta;
        if ($urandom_range(0, 4) == 0) begin
            return pick_coord();
        end
        delta = int'($urandom_range(0, 2 * span)) - span;
        return own + COORD_W'(delta);
    endfunction

    // One population of well-formed members; last_member also shows up as noise mid-member.
    task automatic queue_population(input int members, inout int count);
        int                 dims;
        int                 span;
        logic [COORD_W-1:0] own;
        for (int m = 0; m < members; m++) begin
            dims = ($urandom_range(0, 9) == 0) ? $urandom_range(1, DIMS_LIMIT)
                                               : $urandom_range(1, 4);
            span = $urandom_range(1, int'(radius) / 2 + 1);
            for (int c = 0; c < dims; c++) begin
                own = pick_coord();
                queue_pair(own, pick_partner(own, span), c == dims - 1,
                           (c == dims - 1) ? (m == members - 1) : ($urandom_range(0, 3) == 0));
                count++;
            end
        end
    endtask

    task automatic run_random_phase(input int items);
        int count;
        count = 0;
        while (count < items) begin
            queue_population($urandom_range(1, 6), count);
        end
        wait_idle();
    endtask

    initial begin : limit_guard
        #(TIMEOUT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin : stimulus
        in_if.valid = 1'b0;
        in_if.own_coord = '0;
        in_if.other_coord = '0;
        in_if.last_coord = 1'b0;
        in_if.last_member = 1'b0;
        out_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset value of the radius, and a write to the unused index leaves it alone.
        cfg_read_check(REG_SIGMA, APB_DATA_W'(SIGMA_RESET));
        cfg_write(REG_SPARE, $urandom());
        cfg_read_check(REG_SIGMA, APB_DATA_W'(SIGMA_RESET));

        // Directed pairs at a radius of 1.0.
        // Identical points share fully.
        queue_pair('0, '0, 1'b1, 1'b1);
        // Coordinates at opposite extremes are far outside the radius.
        queue_pair(COORD_MIN, COORD_MAX, 1'b1, 1'b1);
        queue_pair(COORD_MAX, COORD_MIN, 1'b1, 1'b1);
        // A last-member flag without last coordinate is ignored.
        queue_pair(24'h010000, '0, 1'b0, 1'b1);
        queue_pair('0, '0, 1'b1, 1'b0);
        queue_pair('0, 24'h004000, 1'b1, 1'b1);
        // Two dimensions forming a 3-4-5 triangle give an exact root.
        queue_pair(24'h003000, '0, 1'b0, 1'b0);
        queue_pair(24'hFFC000, '0, 1'b1, 1'b1);
        // Negative coordinates and a tiny distance across zero.
        queue_pair(24'hFF0000, 24'hFF8000, 1'b1, 1'b0);
        queue_pair(COORD_MAX, COORD_MAX, 1'b1, 1'b0);
        queue_pair(24'hFFFFFF, 24'h000001, 1'b1, 1'b1);
        wait_idle();

        // Random populations over several radii, the extremes and zero among them.
        cfg_write(REG_SIGMA, 32'd1);
        run_random_phase(80);
        cfg_write(REG_SIGMA, APB_DATA_W'(SIGMA_MAX));
        cfg_read_check(REG_SIGMA, APB_DATA_W'(SIGMA_MAX));
        run_random_phase(70);
        cfg_write(REG_SIGMA, 32'd0);
        run_random_phase(40);
        cfg_write(REG_SIGMA, $urandom_range(1, 1 << 20));
        run_random_phase(90);
        cfg_write(REG_SIGMA, $urandom_range(1, int'(SIGMA_MAX)));
        run_random_phase(90);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
